// ----- src/pxe_pkg.sv -----
// Shared types and constants for the WS2812 pixel encoder.
// Used by the lane, the bit serializer and the top level.
`default_nettype none

package pxe_pkg;

  localparam int CHAN_W    = 8;
  localparam int NUM_LANES = 3;
  localparam int WORD_W    = CHAN_W * NUM_LANES;
  localparam int PCT_W     = 7;
  localparam int DUTY_W    = 10;
  localparam int CNT_W     = $clog2(WORD_W + 1);
  localparam int OUT_DATA_W = ((2 * DUTY_W + 7) / 8) * 8;

  // Full brightness scale and the reciprocal that divides by it.
  localparam int          FULL_SCALE = 100;
  localparam int          PROD_W     = CHAN_W + PCT_W;
  localparam int          RECIP_SH   = 19;
  localparam int          RECIP_W    = 13;
  localparam int          MUL_W      = PROD_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(((1 << RECIP_SH) + FULL_SCALE - 1) / FULL_SCALE);

  // Register indexes of the configuration port.
  localparam logic [1:0] REG_BRIGHTNESS = 2'd0;
  localparam logic [1:0] REG_ONE_DUTY   = 2'd1;
  localparam logic [1:0] REG_ZERO_DUTY  = 2'd2;
  localparam logic [1:0] REG_RESET_SLOTS = 2'd3;

  localparam logic [PCT_W-1:0]  PCT_RESET   = PCT_W'(FULL_SCALE);
  localparam logic [DUTY_W-1:0] ONE_RESET   = DUTY_W'(134);
  localparam logic [DUTY_W-1:0] ZERO_RESET  = DUTY_W'(67);
  localparam logic [DUTY_W-1:0] SLOTS_RESET = DUTY_W'(200);

  typedef struct packed {
    logic [DUTY_W-1:0] one_duty;
    logic [DUTY_W-1:0] zero_duty;
    logic [DUTY_W-1:0] reset_slots;
  } duty_cfg_t;

  typedef struct packed {
    logic [WORD_W-1:0] word;   // green in the top byte, blue in the bottom byte
    logic              last;
  } pxl_t;

endpackage : pxe_pkg

`default_nettype wire

// ----- src/pxe_lane.sv -----
// One color lane: scales a channel byte by the brightness percent.
// Two registered multiplies; the second divides by 100 via a reciprocal. Uses pxe_pkg.
`default_nettype none

module pxe_lane (
  input  wire logic                       clk,
  input  wire logic                       en,
  input  wire logic [pxe_pkg::CHAN_W-1:0] chan,
  input  wire logic [pxe_pkg::PCT_W-1:0]  pct,
  output logic      [pxe_pkg::CHAN_W-1:0] scaled
);
  import pxe_pkg::*;

  logic [PROD_W-1:0] prod_r, prod_nxt;
  logic [CHAN_W-1:0] scaled_r, scaled_nxt;
  logic [MUL_W-1:0]  mul;

  // Products stay below 25501, where the reciprocal gives the exact floor.
  assign prod_nxt   = PROD_W'(chan) * PROD_W'(pct);
  assign mul        = MUL_W'(prod_r) * MUL_W'(RECIP);
  assign scaled_nxt = mul[RECIP_SH +: CHAN_W];

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r   <= prod_nxt;
      scaled_r <= scaled_nxt;
    end
  end

  assign scaled = scaled_r;

endmodule : pxe_lane

`default_nettype wire

// ----- src/pxe_ser.sv -----
// Bit serializer (uses pxe_pkg): takes the merged lane word and emits, through an
// output register, one slot per cycle while not stalled, plus the frame trailer.
`default_nettype none

module pxe_ser (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           pix_valid,
  input  wire pxe_pkg::pxl_t                  pix,
  input  wire pxe_pkg::duty_cfg_t             cfg,
  output logic                                pix_load,
  output logic                                out_tvalid,
  input  wire logic                           out_tready,
  output logic [pxe_pkg::OUT_DATA_W-1:0]      out_tdata,
  output logic                                out_tlast
);
  import pxe_pkg::*;

  logic [WORD_W-1:0] word_r, word_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              trl_r, trl_nxt;
  logic              ov_r, ov_nxt;
  logic [DUTY_W-1:0] hi_r, hi_nxt;
  logic [DUTY_W-1:0] rep_r, rep_nxt;
  logic              end_r, end_nxt;
  logic              active, emit, final_slot;

  assign active     = (cnt_r != '0) || trl_r;
  assign emit       = active && (!ov_r || out_tready);
  assign final_slot = emit && ((cnt_r == CNT_W'(1) && !trl_r) || (cnt_r == '0));
  assign pix_load   = pix_valid && (!active || final_slot);

  always_comb begin
    word_nxt = word_r;
    cnt_nxt  = cnt_r;
    trl_nxt  = trl_r;
    ov_nxt   = ov_r;
    hi_nxt   = hi_r;
    rep_nxt  = rep_r;
    end_nxt  = end_r;
    if (emit) begin
      ov_nxt = 1'b1;
      if (cnt_r != '0) begin
        hi_nxt   = word_r[WORD_W-1] ? cfg.one_duty : cfg.zero_duty;
        rep_nxt  = DUTY_W'(1);
        end_nxt  = 1'b0;
        word_nxt = {word_r[WORD_W-2:0], 1'b0};
        cnt_nxt  = cnt_r - CNT_W'(1);
      end else begin
        hi_nxt  = '0;
        rep_nxt = cfg.reset_slots;
        end_nxt = 1'b1;
        trl_nxt = 1'b0;
      end
    end else if (out_tready) begin
      ov_nxt = 1'b0;
    end
    if (pix_load) begin
      word_nxt = pix.word;
      cnt_nxt  = CNT_W'(WORD_W);
      trl_nxt  = pix.last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      trl_r <= 1'b0;
      ov_r  <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      trl_r <= trl_nxt;
      ov_r  <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
    hi_r   <= hi_nxt;
    rep_r  <= rep_nxt;
    end_r  <= end_nxt;
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = OUT_DATA_W'({rep_r, hi_r});
  assign out_tlast  = end_r;

endmodule : pxe_ser

`default_nettype wire

// ----- src/ws2812_pixel_encoder_core.sv -----
// Path: a pixel passes the lane product and scaled registers, the serializer word and its output register.
// Throughput: one slot result per cycle while out_tready allows; a pixel gives 24 slots
// (25 with the trailer), set by the serializer that shifts out one bit per output transfer.
// Reset: rst_n is synchronous and active low; it empties the pipeline and the output
// register and returns the registers to brightness 100, duties 134 and 67, 200 reset slots.
`default_nettype none

module ws2812_pixel_encoder_core (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // Pixel input stream.
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  input  wire logic [pxe_pkg::WORD_W-1:0]      in_tdata,   // green[7:0], red[15:8], blue[23:16]
  input  wire logic                            in_tlast,   // last pixel of the frame
  // Slot result stream.
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  output logic [pxe_pkg::OUT_DATA_W-1:0]       out_tdata,  // high_time[9:0], slot_repeat[19:10], zeros
  output logic                                 out_tlast,  // frame end (trailer result)
  // Configuration write port.
  input  wire logic                            cfg_we,
  input  wire logic [1:0]                      cfg_addr,
  input  wire logic [pxe_pkg::DUTY_W-1:0]      cfg_wdata
);
  import pxe_pkg::*;

  // Configuration registers. Brightness writes are clamped to full scale and a
  // zero reset length is stored as one slot, so the trailer never vanishes.
  logic [PCT_W-1:0]  pct_r, pct_nxt;
  logic [DUTY_W-1:0] one_r, one_nxt;
  logic [DUTY_W-1:0] zero_r, zero_nxt;
  logic [DUTY_W-1:0] slots_r, slots_nxt;

  always_comb begin
    pct_nxt   = pct_r;
    one_nxt   = one_r;
    zero_nxt  = zero_r;
    slots_nxt = slots_r;
    if (cfg_we) begin
      case (cfg_addr)
        REG_BRIGHTNESS: begin
          pct_nxt = (cfg_wdata[PCT_W-1:0] > PCT_RESET) ? PCT_RESET : cfg_wdata[PCT_W-1:0];
        end
        REG_ONE_DUTY: begin
          one_nxt = cfg_wdata;
        end
        REG_ZERO_DUTY: begin
          zero_nxt = cfg_wdata;
        end
        REG_RESET_SLOTS: begin
          slots_nxt = (cfg_wdata == '0) ? DUTY_W'(1) : cfg_wdata;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pct_r   <= PCT_RESET;
      one_r   <= ONE_RESET;
      zero_r  <= ZERO_RESET;
      slots_r <= SLOTS_RESET;
    end else begin
      pct_r   <= pct_nxt;
      one_r   <= one_nxt;
      zero_r  <= zero_nxt;
      slots_r <= slots_nxt;
    end
  end

  // Two-stage scaling pipeline. All three lanes advance together; the pipeline
  // moves whenever its last stage is empty or the serializer takes that pixel,
  // so a new pixel is accepted while the previous one is still being shifted out.
  logic              v1_r, v1_nxt, v2_r, v2_nxt;
  logic              last1_r, last2_r;
  logic              pipe_en, pix_load;
  logic [CHAN_W-1:0] lane_in  [NUM_LANES];
  logic [CHAN_W-1:0] lane_out [NUM_LANES];
  pxl_t              pix;
  duty_cfg_t         duty_cfg;

  assign pipe_en   = !v2_r || pix_load;
  assign in_tready = pipe_en;
  assign v1_nxt    = pipe_en ? in_tvalid : v1_r;
  assign v2_nxt    = pipe_en ? v1_r : v2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= v1_nxt;
      v2_r <= v2_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      last1_r <= in_tlast;
      last2_r <= last1_r;
    end
  end

  // Lane 0 is green, lane 1 red, lane 2 blue.
  for (genvar i = 0; i < NUM_LANES; i++) begin : g_lane
    assign lane_in[i] = in_tdata[i*CHAN_W +: CHAN_W];
    pxe_lane u_lane (
      .clk    (clk),
      .en     (pipe_en),
      .chan   (lane_in[i]),
      .pct    (pct_r),
      .scaled (lane_out[i])
    );
  end

  // Merge: green is sent first, so it takes the top of the shift word.
  assign pix.word = {lane_out[0], lane_out[1], lane_out[2]};
  assign pix.last = last2_r;

  assign duty_cfg.one_duty    = one_r;
  assign duty_cfg.zero_duty   = zero_r;
  assign duty_cfg.reset_slots = slots_r;

  pxe_ser u_ser (
    .clk        (clk),
    .rst_n      (rst_n),
    .pix_valid  (v2_r),
    .pix        (pix),
    .cfg        (duty_cfg),
    .pix_load   (pix_load),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

`ifndef SYNTH
  // The trailer carries a low level over at least one slot.
  a_trailer_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tdata[DUTY_W-1:0] == '0 && out_tdata[2*DUTY_W-1:DUTY_W] != '0)
    else $error("trailer result malformed");

  // Data slots always cover exactly one slot.
  a_data_repeat: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> out_tdata[2*DUTY_W-1:DUTY_W] == DUTY_W'(1))
    else $error("data slot repeat is not one");

  // A held pixel in the last stage blocks new input transfers.
  a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    v2_r && !pix_load |-> !in_tready)
    else $error("input accepted while the pipeline is full");

  // A pixel that is not taken stays in the last stage.
  a_pixel_held: assert property (@(posedge clk) disable iff (!rst_n)
    v2_r && !pix_load |=> v2_r && $stable(pix))
    else $error("pending pixel lost");
`endif

endmodule : ws2812_pixel_encoder_core

`default_nettype wire
